// File: src/mme_pkg.sv
// ----------------------------------------------------------------------------
// mme_pkg
// Shared constants, codes and control/status types for the matrix multiply
// engine.
// ----------------------------------------------------------------------------
package mme_pkg;

    // Matrix geometry
    localparam int MAX_DIM = 8;
    localparam int IDX_W   = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int DIM_W   = 4;
    localparam int ADDR_W  = 2 * IDX_W;
    localparam int DEPTH   = 2 ** ADDR_W;

    // Arithmetic widths
    localparam int ELEM_W  = 16;
    localparam int PROD_W  = 2 * ELEM_W;
    localparam int ACC_W   = 35;

    // Request opcodes
    localparam int OPC_W = 2;
    localparam logic [OPC_W-1:0] OP_WRITE_A = 2'd0;
    localparam logic [OPC_W-1:0] OP_WRITE_B = 2'd1;
    localparam logic [OPC_W-1:0] OP_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_M  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INNER_K = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_N  = 2'd2;
    localparam logic [DIM_W-1:0]     DIM_RESET   = DIM_W'(MAX_DIM);

    // Controller to datapath commands
    typedef struct packed {
        logic             wr_a;      // store A element from input request
        logic             wr_b;      // store B element from input request
        logic             rd_en;     // read one A/B pair
        logic [IDX_W-1:0] row;       // current result row
        logic [IDX_W-1:0] col;       // current result column
        logic [IDX_W-1:0] step;      // current summation index
        logic             acc_clear; // start a new dot product
        logic             out_load;  // move accumulator to output register
        logic             out_last;  // final element of the matrix
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_free; // output register can take a new result
    } sts_t;

endpackage

// File: src/matrix_multiply_engine_top.sv
// ----------------------------------------------------------------------------
// matrix_multiply_engine_top
// General matrix multiply C = A * B over signed Q8.8 elements, results in
// exact signed Q19.16.
// ----------------------------------------------------------------------------
// Load requests (opcode 0 for A, 1 for B) are taken one per cycle while the
// engine is idle. A compute request emits every element of C in row-major
// order with m_out_last on the final one. For each result the engine reads
// its K A/B pairs from the single read port of each element store, drains
// the multiply/accumulate pipeline and then moves the sum into the output
// register, waiting there while the result side stalls. The next request
// is accepted once the final result has entered the output register.
module matrix_multiply_engine_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Configuration
    input  logic                               cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]          cfg_data,
    // Request channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [mme_pkg::OPC_W-1:0]          s_opcode,
    input  logic [mme_pkg::IDX_W-1:0]          s_row_index,
    input  logic [mme_pkg::IDX_W-1:0]          s_col_index,
    input  logic signed [mme_pkg::ELEM_W-1:0]  s_element_value,
    // Result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mme_pkg::IDX_W-1:0]          m_out_row,
    output logic [mme_pkg::IDX_W-1:0]          m_out_col,
    output logic signed [mme_pkg::ACC_W-1:0]   m_out_value,
    output logic                               m_out_last
);
    import mme_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Sequencer and configuration
    mme_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_opcode  (s_opcode),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Stores, MAC and output register
    mme_datapath u_datapath (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (cmd),
        .sts             (sts),
        .s_row_index     (s_row_index),
        .s_col_index     (s_col_index),
        .s_element_value (s_element_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_out_row       (m_out_row),
        .m_out_col       (m_out_col),
        .m_out_value     (m_out_value),
        .m_out_last      (m_out_last)
    );

endmodule

// File: src/mme_ctrl.sv
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: configuration registers, request decode and the sequencer
// that walks rows, columns and the summation index of a compute request.
// ----------------------------------------------------------------------------
module mme_ctrl (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_we,
    input  logic [mme_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mme_pkg::DIM_W-1:0]      cfg_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [mme_pkg::OPC_W-1:0]      s_opcode,
    input  mme_pkg::sts_t                  sts,
    output mme_pkg::cmd_t                  cmd
);
    import mme_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_DRAIN1 = 3'd2;
    localparam logic [2:0] ST_DRAIN2 = 3'd3;
    localparam logic [2:0] ST_OUT    = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [DIM_W-1:0] rows_m_reg, inner_k_reg, cols_n_reg;

    logic [DIM_W-1:0] dim_m, dim_k, dim_n;
    logic [IDX_W-1:0] last_row, last_col, last_step;
    logic             accept, is_last, row_end;
    logic [2:0]       first_state;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_m_reg  <= DIM_RESET;
            inner_k_reg <= DIM_RESET;
            cols_n_reg  <= DIM_RESET;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ROWS_M:  rows_m_reg  <= cfg_data;
                CFG_INNER_K: inner_k_reg <= cfg_data;
                CFG_COLS_N:  cols_n_reg  <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Dimensions above the store size are taken as the store size
    assign dim_m = (rows_m_reg  > DIM_RESET) ? DIM_RESET : rows_m_reg;
    assign dim_k = (inner_k_reg > DIM_RESET) ? DIM_RESET : inner_k_reg;
    assign dim_n = (cols_n_reg  > DIM_RESET) ? DIM_RESET : cols_n_reg;

    // Last index values; only used when the dimension is nonzero
    assign last_row  = IDX_W'(dim_m - DIM_W'(1));
    assign last_col  = IDX_W'(dim_n - DIM_W'(1));
    assign last_step = IDX_W'(dim_k - DIM_W'(1));

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign row_end     = (col_reg == last_col);
    assign is_last     = (row_reg == last_row) && row_end;
    // An empty summation skips the read phase
    assign first_state = (dim_k == '0) ? ST_DRAIN1 : ST_READ;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        row_next      = row_reg;
        col_next      = col_reg;
        step_next     = step_reg;
        cmd           = '0;
        cmd.row       = row_reg;
        cmd.col       = col_reg;
        cmd.step      = step_reg;
        cmd.out_last  = is_last;

        case (state_reg)
            ST_IDLE: begin
                cmd.wr_a = accept && (s_opcode == OP_WRITE_A);
                cmd.wr_b = accept && (s_opcode == OP_WRITE_B);
                if (accept && (s_opcode == OP_COMPUTE) &&
                    (dim_m != '0) && (dim_n != '0)) begin
                    row_next      = '0;
                    col_next      = '0;
                    step_next     = '0;
                    cmd.acc_clear = 1'b1;
                    state_next    = first_state;
                end
            end
            ST_READ: begin
                cmd.rd_en = 1'b1;
                if (step_reg == last_step) begin
                    step_next  = '0;
                    state_next = ST_DRAIN1;
                end else begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_DRAIN1: state_next = ST_DRAIN2;
            ST_DRAIN2: state_next = ST_OUT;
            ST_OUT: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    if (is_last) begin
                        state_next = ST_IDLE;
                    end else begin
                        cmd.acc_clear = 1'b1;
                        state_next    = first_state;
                        if (row_end) begin
                            col_next = '0;
                            row_next = row_reg + IDX_W'(1);
                        end else begin
                            col_next = col_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            step_reg  <= step_next;
        end
    end

endmodule

// File: src/mme_datapath.sv
// ----------------------------------------------------------------------------
// mme_datapath
// Element stores for A and B, multiply-accumulate pipeline and the result
// output register.
// ----------------------------------------------------------------------------
module mme_datapath (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  mme_pkg::cmd_t                      cmd,
    output mme_pkg::sts_t                      sts,
    input  logic [mme_pkg::IDX_W-1:0]          s_row_index,
    input  logic [mme_pkg::IDX_W-1:0]          s_col_index,
    input  logic signed [mme_pkg::ELEM_W-1:0]  s_element_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [mme_pkg::IDX_W-1:0]          m_out_row,
    output logic [mme_pkg::IDX_W-1:0]          m_out_col,
    output logic signed [mme_pkg::ACC_W-1:0]   m_out_value,
    output logic                               m_out_last
);
    import mme_pkg::*;

    logic [ELEM_W-1:0] mem_a [DEPTH];
    logic [ELEM_W-1:0] mem_b [DEPTH];

    logic [ADDR_W-1:0]        wr_addr, rd_addr_a, rd_addr_b;
    logic                     wr_in_range;
    logic [ELEM_W-1:0]        a_data_reg, b_data_reg;
    logic                     rd_valid_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     prod_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     m_valid_reg;
    logic [IDX_W-1:0]         m_row_reg, m_col_reg;
    logic signed [ACC_W-1:0]  m_value_reg;
    logic                     m_last_reg;

    // Store addresses: A by (row, step), B by (step, col)
    assign wr_addr     = {s_row_index, s_col_index};
    assign rd_addr_a   = {cmd.row, cmd.step};
    assign rd_addr_b   = {cmd.step, cmd.col};
    assign wr_in_range = ({1'b0, s_row_index} < (IDX_W+1)'(MAX_DIM)) &&
                         ({1'b0, s_col_index} < (IDX_W+1)'(MAX_DIM));

    // A store
    always_ff @(posedge aclk) begin
        if (cmd.wr_a && wr_in_range) begin
            mem_a[wr_addr] <= s_element_value;
        end
        if (cmd.rd_en) begin
            a_data_reg <= mem_a[rd_addr_a];
        end
    end

    // B store
    always_ff @(posedge aclk) begin
        if (cmd.wr_b && wr_in_range) begin
            mem_b[wr_addr] <= s_element_value;
        end
        if (cmd.rd_en) begin
            b_data_reg <= mem_b[rd_addr_b];
        end
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (rd_valid_reg) begin
            prod_reg <= $signed(a_data_reg) * $signed(b_data_reg);
        end
    end

    // Accumulate stage, exact in ACC_W bits
    always_ff @(posedge aclk) begin
        if (cmd.acc_clear) begin
            acc_reg <= '0;
        end else if (prod_valid_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Pipeline valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg   <= cmd.rd_en;
            prod_valid_reg <= rd_valid_reg;
        end
    end

    // Output register
    assign sts.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_row_reg   <= cmd.row;
            m_col_reg   <= cmd.col;
            m_value_reg <= acc_reg;
            m_last_reg  <= cmd.out_last;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_row   = m_row_reg;
    assign m_out_col   = m_col_reg;
    assign m_out_value = m_value_reg;
    assign m_out_last  = m_last_reg;

endmodule
